// File: src/mlpq_pkg.sv
// ----------------------------------------------------------------------------
// mlpq_pkg
// Shared constants, codes and types of the multi-level priority queue.
// ----------------------------------------------------------------------------
`default_nettype none

package mlpq_pkg;

  // Number of priority levels and slots per level.
  localparam int LEVELS = 4;
  localparam int DEPTH  = 8;

  // Widths of the interface fields.
  localparam int DATA_W   = 32;
  localparam int LEVEL_W  = 2;
  localparam int STATUS_W = 2;

  // Internal widths.
  localparam int LVL_W     = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int PTR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int ADDR_W    = LVL_W + PTR_W;
  localparam int RAM_DEPTH = 1 << ADDR_W;

  // Byte-padded tdata widths.
  localparam int S_TDATA_W = ((LEVEL_W + DATA_W + 7) / 8) * 8;
  localparam int M_TDATA_W = ((DATA_W + LEVEL_W + 7) / 8) * 8;

  typedef enum logic {
    OP_ENQ = 1'b0,
    OP_DEQ = 1'b1
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_ENQUEUED  = 2'd0,
    ST_FULL      = 2'd1,
    ST_DEQUEUED  = 2'd2,
    ST_UNDERFLOW = 2'd3
  } status_e;

  // Decision of the control unit for one accepted operation.
  typedef struct packed {
    logic              we;
    logic              re;
    logic [ADDR_W-1:0] addr;
    status_e           status;
    logic [LVL_W-1:0]  lvl;
  } mlpq_op_t;

endpackage

`default_nettype wire

// File: src/mlpq_ram.sv
// ----------------------------------------------------------------------------
// mlpq_ram
// Generic single-write, single-read RAM with a registered, enabled read port.
// ----------------------------------------------------------------------------
`default_nettype none

module mlpq_ram #(
  parameter int Width = 32,
  parameter int Depth = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// File: src/mlpq_ctrl.sv
// ----------------------------------------------------------------------------
// mlpq_ctrl
// Per-level front and rear pointers, occupancy flags and the decision logic.
// ----------------------------------------------------------------------------
`default_nettype none

module mlpq_ctrl (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    accept_i,
  input  wire logic                    op_i,
  input  wire logic [mlpq_pkg::LEVEL_W-1:0] level_i,
  output mlpq_pkg::mlpq_op_t           op_o
);
  import mlpq_pkg::*;

  logic [PTR_W-1:0] front_q [LEVELS];
  logic [PTR_W-1:0] front_d [LEVELS];
  logic [PTR_W-1:0] rear_q  [LEVELS];
  logic [PTR_W-1:0] rear_d  [LEVELS];
  logic [LEVELS-1:0] occ_q, occ_d;

  logic [LVL_W-1:0] lvl_idx;
  logic             in_range;
  logic             found;
  logic [LVL_W-1:0] sel;

  assign lvl_idx  = LVL_W'(level_i);
  assign in_range = (int'(level_i) < LEVELS);

  // Lowest-numbered occupied level.
  always_comb begin
    found = 1'b0;
    sel   = '0;
    for (int i = LEVELS - 1; i >= 0; i--) begin
      if (occ_q[i]) begin
        found = 1'b1;
        sel   = LVL_W'(i);
      end
    end
  end

  always_comb begin
    front_d   = front_q;
    rear_d    = rear_q;
    occ_d     = occ_q;
    op_o.we     = 1'b0;
    op_o.re     = 1'b0;
    op_o.addr   = '0;
    op_o.status = ST_FULL;
    op_o.lvl    = '0;
    if (op_i == OP_ENQ) begin
      if (!in_range) begin
        op_o.status = ST_FULL;
      end else if (!occ_q[lvl_idx]) begin
        op_o.we          = 1'b1;
        op_o.addr        = {lvl_idx, PTR_W'(0)};
        op_o.status      = ST_ENQUEUED;
        occ_d[lvl_idx]   = 1'b1;
        front_d[lvl_idx] = '0;
        rear_d[lvl_idx]  = '0;
      end else if (rear_q[lvl_idx] == PTR_W'(DEPTH - 1)) begin
        op_o.status = ST_FULL;
      end else begin
        op_o.we         = 1'b1;
        op_o.addr       = {lvl_idx, PTR_W'(rear_q[lvl_idx] + 1'b1)};
        op_o.status     = ST_ENQUEUED;
        rear_d[lvl_idx] = PTR_W'(rear_q[lvl_idx] + 1'b1);
      end
    end else begin
      if (found) begin
        op_o.re     = 1'b1;
        op_o.addr   = {sel, front_q[sel]};
        op_o.status = ST_DEQUEUED;
        op_o.lvl    = sel;
        if (front_q[sel] >= rear_q[sel]) begin
          occ_d[sel]   = 1'b0;
          front_d[sel] = '0;
          rear_d[sel]  = '0;
        end else begin
          front_d[sel] = PTR_W'(front_q[sel] + 1'b1);
        end
      end else begin
        op_o.status = ST_UNDERFLOW;
      end
    end
    // Nothing moves unless the operation is actually taken.
    if (!accept_i) begin
      op_o.we = 1'b0;
      op_o.re = 1'b0;
      front_d = front_q;
      rear_d  = rear_q;
      occ_d   = occ_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
      for (int i = 0; i < LEVELS; i++) begin
        front_q[i] <= '0;
        rear_q[i]  <= '0;
      end
    end else begin
      occ_q   <= occ_d;
      front_q <= front_d;
      rear_q  <= rear_d;
    end
  end

endmodule

`default_nettype wire

// File: src/multi_level_priority_queue.sv
// Output: a result beat appears in the cycle after its request beat is taken.
// Throughput: one operation per cycle unless stalled; the slot RAM's
// registered read port delivers the dequeued value with the result register.
// Reset: asynchronous, active low; every level is empty after reset and the
// slot RAM needs no clearing, so requests are taken from the first cycle.
// ----------------------------------------------------------------------------
// multi_level_priority_queue
// Priority queue made of one linear queue per priority level, sharing one
// slot RAM, with stream interfaces on both sides.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_level_priority_queue (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // Request side.
  input  wire logic                          s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // tdata, lowest bit first: level (2), value (32), zero padding.
  input  wire logic [mlpq_pkg::S_TDATA_W-1:0] s_axis_tdata_i,
  // tuser: operation (1), 0 enqueue, 1 dequeue.
  input  wire logic [0:0]                    s_axis_tuser_i,
  // Result side.
  output logic                               m_axis_tvalid_o,
  input  wire logic                          m_axis_tready_i,
  // tdata, lowest bit first: item_out (32), level_out (2), zero padding.
  output logic      [mlpq_pkg::M_TDATA_W-1:0] m_axis_tdata_o,
  // tuser: status (2).
  output logic      [mlpq_pkg::STATUS_W-1:0] m_axis_tuser_o
);
  import mlpq_pkg::*;

  // Handshake and request fields.
  logic                accept;
  logic [LEVEL_W-1:0]  in_level;
  logic [DATA_W-1:0]   in_value;
  logic                in_op;
  mlpq_op_t            ctrl_op;

  // Result register. The dequeued value itself sits in the RAM's read
  // register, which is only enabled on a dequeue, so it holds during stalls.
  logic                valid_q, valid_d;
  status_e             status_q;
  logic [LVL_W-1:0]    lvl_q;
  logic                deq_q;
  logic [DATA_W-1:0]   rd_data;
  logic [DATA_W-1:0]   item_out;

  assign in_level = s_axis_tdata_i[LEVEL_W-1:0];
  assign in_value = s_axis_tdata_i[LEVEL_W+DATA_W-1:LEVEL_W];
  assign in_op    = s_axis_tuser_i[0];

  // A new request is taken whenever the result register is free or is
  // being emptied in this same cycle.
  assign s_axis_tready_o = !valid_q || m_axis_tready_i;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  // Pointer bookkeeping and the priority scan over the occupancy flags.
  mlpq_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .op_i     (in_op),
    .level_i  (in_level),
    .op_o     (ctrl_op)
  );

  // Slot storage, addressed as {level, slot}. An enqueue writes and a
  // dequeue reads, never both at once, so one shared address suffices.
  // A written value is visible to any later read, which covers
  // a dequeue right after an enqueue into an empty level.
  mlpq_ram #(
    .Width (DATA_W),
    .Depth (RAM_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ctrl_op.we),
    .waddr_i (ctrl_op.addr),
    .wdata_i (in_value),
    .re_i    (ctrl_op.re),
    .raddr_i (ctrl_op.addr),
    .rdata_o (rd_data)
  );

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload registers load only on an accepted request.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= ctrl_op.status;
      lvl_q    <= ctrl_op.lvl;
      deq_q    <= (ctrl_op.status == ST_DEQUEUED);
    end
  end

  // Item and level read as zero for every status other than a dequeue.
  assign item_out        = deq_q ? rd_data : '0;
  assign m_axis_tvalid_o = valid_q;
  assign m_axis_tuser_o  = status_q;
  assign m_axis_tdata_o  = M_TDATA_W'({LEVEL_W'(lvl_q), item_out});

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------

  // A taken request always produces a result beat in the next cycle.
  a_result_follows : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    accept |=> m_axis_tvalid_o
  ) else $error("accepted request did not produce a result beat");

  // A successful enqueue leaves at least one level occupied, so a dequeue
  // taken right after it cannot report underflow.
  a_no_underflow_after_enq : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (accept && in_op == OP_ENQ && ctrl_op.status == ST_ENQUEUED)
      |=> !(accept && in_op == OP_DEQ && ctrl_op.status == ST_UNDERFLOW)
  ) else $error("underflow reported right after a successful enqueue");

  // The RAM is only touched by a taken request, and never read and written
  // in the same cycle.
  a_ram_access : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (ctrl_op.we || ctrl_op.re) |-> (accept && !(ctrl_op.we && ctrl_op.re))
  ) else $error("illegal slot RAM access");

endmodule

`default_nettype wire
